/* hdl/swsb_pkg.sv */
// shared types and constants for the sliding window slot buffer
package swsb_pkg;

  localparam int DEPTH        = 64;                 // must be a power of two
  localparam int PAYLOAD_BITS = 64;
  localparam int SLOT_W       = $clog2(DEPTH);
  localparam int STEP_W       = $clog2(DEPTH + 1);
  localparam int MODE_W       = 4;
  localparam int INDEX_W      = 32;
  localparam int WORD_W       = 64;
  localparam int POS_W        = INDEX_W + 2;        // holds rear + DEPTH and pos - front

  localparam logic [MODE_W-1:0] MODE_WRITE      = 4'd0;
  localparam logic [MODE_W-1:0] MODE_READ       = 4'd1;
  localparam logic [MODE_W-1:0] MODE_SET_FLAG   = 4'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR_FLAG = 4'd3;
  localparam logic [MODE_W-1:0] MODE_TEST_FLAG  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_SET_FRONT  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_SET_REAR   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SCAN_FRONT = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SCAN_REAR  = 4'd8;

  typedef struct packed {
    logic latch;       // capture the input word
    logic exec;        // perform the operation, start a scan
    logic scan_step;   // advance the scan position
    logic load_out;    // load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic              is_scan;
    logic              scan_more;
    logic [STEP_W-1:0] steps;
  } dp_stat_t;

endpackage

/* hdl/swsb_ctrl.sv */
// controller state machine for the sliding window slot buffer
module swsb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  swsb_pkg::dp_stat_t  stat,
  output swsb_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = stat.is_scan ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan_step = stat.scan_more;
        if (!stat.scan_more) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/swsb_dp.sv */
// datapath of the sliding window slot buffer: slots, flags, window and scan unit
module swsb_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swsb_pkg::ctrl_cmd_t                   cmd,
  output swsb_pkg::dp_stat_t                    stat,
  input  logic [swsb_pkg::MODE_W-1:0]           mode,
  input  logic signed [swsb_pkg::INDEX_W-1:0]   seq_index,
  input  logic [swsb_pkg::WORD_W-1:0]           payload_in,
  output logic [swsb_pkg::WORD_W-1:0]           payload_out,
  output logic                                  flag_out,
  output logic signed [swsb_pkg::INDEX_W-1:0]   position_out
);

  localparam logic signed [swsb_pkg::POS_W-1:0] DEPTH_POS =
    swsb_pkg::POS_W'(swsb_pkg::DEPTH);
  localparam logic [swsb_pkg::STEP_W-1:0] DEPTH_STEPS =
    swsb_pkg::STEP_W'(swsb_pkg::DEPTH);

  logic [swsb_pkg::MODE_W-1:0]             mode_q;
  logic signed [swsb_pkg::INDEX_W-1:0]     idx_q;
  logic [swsb_pkg::PAYLOAD_BITS-1:0]       pay_q;
  logic signed [swsb_pkg::INDEX_W-1:0]     front;
  logic signed [swsb_pkg::INDEX_W-1:0]     rear;
  logic [swsb_pkg::DEPTH-1:0]              flags;
  logic [swsb_pkg::PAYLOAD_BITS-1:0]       mem [swsb_pkg::DEPTH];
  logic [swsb_pkg::PAYLOAD_BITS-1:0]       rd_data;
  logic                                    flag_q;
  logic signed [swsb_pkg::POS_W-1:0]       pos;
  logic [swsb_pkg::STEP_W-1:0]             steps;

  logic [swsb_pkg::SLOT_W-1:0]             slot;
  logic [swsb_pkg::SLOT_W-1:0]             pos_slot;
  logic signed [swsb_pkg::POS_W-1:0]       front_ext;
  logic signed [swsb_pkg::POS_W-1:0]       rear_ext;
  logic signed [swsb_pkg::POS_W-1:0]       rear_span;
  logic signed [swsb_pkg::POS_W-1:0]       pos_less;
  logic                                    pos_flag;
  logic                                    room;
  logic                                    front_more;
  logic                                    rear_more;

  logic [swsb_pkg::WORD_W-1:0]             res_payload;
  logic                                    res_flag;
  logic signed [swsb_pkg::INDEX_W-1:0]     res_pos;

  // power-of-two depth: floor modulo is the low bits, also for negatives
  assign slot      = idx_q[swsb_pkg::SLOT_W-1:0];
  assign pos_slot  = pos[swsb_pkg::SLOT_W-1:0];
  assign front_ext = swsb_pkg::POS_W'(front);
  assign rear_ext  = swsb_pkg::POS_W'(rear);
  assign rear_span = pos - front_ext;
  assign pos_less  = pos - swsb_pkg::POS_W'(1);
  assign pos_flag  = flags[pos_slot];
  assign room      = steps < DEPTH_STEPS;

  assign front_more = room && (pos <= rear_ext) && pos_flag;
  assign rear_more  = room && !pos_flag && (rear_span < DEPTH_POS);

  assign stat.is_scan   = (mode_q == swsb_pkg::MODE_SCAN_FRONT) ||
                          (mode_q == swsb_pkg::MODE_SCAN_REAR);
  assign stat.scan_more = (mode_q == swsb_pkg::MODE_SCAN_FRONT) ? front_more : rear_more;
  assign stat.steps     = steps;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= mode;
      idx_q  <= seq_index;
      pay_q  <= payload_in[swsb_pkg::PAYLOAD_BITS-1:0];
    end
  end

  // slot store, read data registered
  always_ff @(posedge clk) begin
    if (cmd.exec && (mode_q == swsb_pkg::MODE_WRITE)) begin
      mem[slot] <= pay_q;
    end
    rd_data <= mem[slot];
  end

  // flags and window
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
      front <= '0;
      rear  <= '0;
    end else if (cmd.exec) begin
      unique case (mode_q)
        swsb_pkg::MODE_SET_FLAG: flags[slot] <= 1'b1;
        swsb_pkg::MODE_CLEAR_FLAG: begin
          if (!idx_q[swsb_pkg::INDEX_W-1]) begin
            flags[slot] <= 1'b0;
          end
        end
        swsb_pkg::MODE_SET_FRONT: begin
          if (idx_q > front) begin
            front <= idx_q;
          end
        end
        swsb_pkg::MODE_SET_REAR: rear <= idx_q;
        default: ;
      endcase
    end
  end

  // scan position and step count
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      flag_q <= flags[slot];
      pos    <= (mode_q == swsb_pkg::MODE_SCAN_FRONT) ? front_ext : rear_ext;
      steps  <= '0;
    end else if (cmd.scan_step) begin
      pos    <= pos + swsb_pkg::POS_W'(1);
      steps  <= steps + swsb_pkg::STEP_W'(1);
    end
  end

  always_comb begin
    res_payload = '0;
    res_flag    = 1'b0;
    res_pos     = '0;
    case (mode_q)
      swsb_pkg::MODE_READ:       res_payload = swsb_pkg::WORD_W'(rd_data);
      swsb_pkg::MODE_TEST_FLAG:  res_flag    = flag_q;
      swsb_pkg::MODE_SET_FRONT:  res_pos     = front;
      swsb_pkg::MODE_SCAN_FRONT: res_pos     = pos[swsb_pkg::INDEX_W-1:0];
      swsb_pkg::MODE_SCAN_REAR:  res_pos     = pos_less[swsb_pkg::INDEX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      payload_out  <= res_payload;
      flag_out     <= res_flag;
      position_out <= res_pos;
    end
  end

endmodule

/* hdl/sliding_window_slot_buffer.sv */
// Sliding window slot buffer for datagrams: top level.
// Input channel (in_valid / in_stall) carries one request word: mode, seq_index and
// payload_in. Output channel (out_valid / out_stall) returns exactly one result word
// per request: payload_out, flag_out and position_out.
// Sequence numbers map onto DEPTH slots by their low bits; each slot has a payload
// word and a received flag. The window front and rear are kept in registers.
// Order: a non-scan request is executed after acceptance, then its result is loaded
// into the output register. A scan walks the flags one slot per cycle, up to DEPTH
// steps plus one final test, before its result is loaded. The next word is taken in
// the cycle after the result is loaded.
// Throughput: one request at a time; in_stall is high from the cycle after
// acceptance until the result is loaded into the output register, so a new request
// can be taken while the previous result still waits on a stalled output.
// Receiver stall: the output register holds its word while out_stall is high; a
// finished result waits inside the block until the register frees up.
// Reset (rst, synchronous): clears all received flags, front and rear to zero and
// drops out_valid. Payload slots are not cleared and must be written before read.
module sliding_window_slot_buffer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [swsb_pkg::MODE_W-1:0]           mode,
  input  logic signed [swsb_pkg::INDEX_W-1:0]   seq_index,
  input  logic [swsb_pkg::WORD_W-1:0]           payload_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [swsb_pkg::WORD_W-1:0]           payload_out,
  output logic                                  flag_out,
  output logic signed [swsb_pkg::INDEX_W-1:0]   position_out
);

  swsb_pkg::ctrl_cmd_t cmd;
  swsb_pkg::dp_stat_t  stat;

  swsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  swsb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .mode         (mode),
    .seq_index    (seq_index),
    .payload_in   (payload_in),
    .payload_out  (payload_out),
    .flag_out     (flag_out),
    .position_out (position_out)
  );

  // the block goes busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after accepting a word");

  // a result never overwrites one that the receiver has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register loaded while stalled");

  // a scan never goes past DEPTH steps
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> (stat.steps < swsb_pkg::STEP_W'(swsb_pkg::DEPTH)))
    else $error("scan ran past the window depth");

  // scans and results do not overlap
  a_step_not_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.scan_step && cmd.load_out))
    else $error("scan step and output load in the same cycle");

endmodule
